// ===== rtl/core/rlesd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlesd_pkg
// Shared types and constants for the run-length sprite decoder: result kinds,
// the result record that travels to the output stage, and field constants.
// ----------------------------------------------------------------------------
package rlesd_pkg;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  localparam int unsigned PIXEL_INDEX_W = 32;
  localparam int unsigned DIM_W         = 16;
  localparam int unsigned CHAN_W        = 8;

  // alpha of every written pixel
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  // last byte of the six byte header (width, height, ignored word)
  localparam logic [2:0] HDR_LAST_BYTE = 3'd5;

  // one result record
  typedef struct packed {
    kind_t                    kind;
    logic [PIXEL_INDEX_W-1:0] pixel_index;
    logic [CHAN_W-1:0]        alpha;
    logic [CHAN_W-1:0]        red;
    logic [CHAN_W-1:0]        green;
    logic [CHAN_W-1:0]        blue;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic                     beyond_frame;
  } result_t;

endpackage

// ===== rtl/core/rlesd_out_skid.sv =====
// ----------------------------------------------------------------------------
// rlesd_out_skid
// Output register with one skid entry. The push side stays ready while the
// skid entry is empty, also while the output register holds a request that
// the receiver has not yet taken.
module rlesd_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  rlesd_pkg::result_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output rlesd_pkg::result_t pop_data,
  input  logic              pop_ready
);

  logic               out_valid;
  rlesd_pkg::result_t out_data;
  logic               skid_valid;
  rlesd_pkg::result_t skid_data;

  assign push_ready = !skid_valid;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push_valid;
      end
    end else if (push_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push_valid) begin
        out_data <= push_data;
      end
    end else if (push_valid && !skid_valid) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/core/rle_sprite_rgb565_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_rgb565_decoder
// Parses a run-length coded RGB565 sprite record byte by byte and emits
// pixel, header and completion results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one record byte per request, with
//   start_image set on the first byte of a new record (width low byte).
//   Output channel (out_valid/out_ready): zero or one result per byte:
//   a pixel (index, ARGB8888 expanded from RGB565, beyond_frame flag), a
//   header-parsed marker, or an image-complete marker with the final count.
//   Width and height from the header ride along on every result.
// Throughput: one byte per cycle, sustained, as long as the receiver keeps
//   taking results; each byte is decoded by combinational logic.
// Output: each result is registered, via the skid entry on a stall.
// Stall: an output register plus one skid entry absorb a stalled receiver;
//   in_ready drops only once both hold results.
// Frame area (width * height) is held in a register refreshed every cycle
//   from the header fields; that multiplier is the widest path.
// Reset: rst (synchronous) returns the parser to the first header byte with
//   zero width, height and pixel counter, and empties the output stage.
// ----------------------------------------------------------------------------
module rle_sprite_rgb565_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] pixel_index,
  output logic [7:0]  alpha,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic        beyond_frame
);

  typedef enum logic [2:0] {
    PH_HEADER       = 3'd0,
    PH_COUNT        = 3'd1,
    PH_SKIP         = 3'd2,
    PH_LO           = 3'd3,
    PH_HI           = 3'd4,
    PH_DONE_PENDING = 3'd5,
    PH_IDLE         = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_count, hdr_count_next;
  logic [15:0] frame_width, frame_width_next;
  logic [15:0] frame_height, frame_height_next;
  logic [31:0] pixel_counter, pixel_counter_next;
  logic [7:0]  run_remaining, run_remaining_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [31:0] frame_area;

  logic               accept;
  logic               res_valid;
  rlesd_pkg::result_t res;
  rlesd_pkg::result_t out_res;
  logic               push_ready;

  phase_t      work_phase;
  logic [31:0] skip_sum;
  logic [31:0] pix_inc;
  logic [15:0] word;

  assign accept = in_valid && in_ready;
  assign in_ready = push_ready;

  // frame area, refreshed every cycle from the header fields
  always_ff @(posedge clk) begin
    frame_area <= frame_width * frame_height;
  end

  // per-byte decode
  always_comb begin
    phase_next         = phase;
    hdr_count_next     = hdr_count;
    frame_width_next   = frame_width;
    frame_height_next  = frame_height;
    pixel_counter_next = pixel_counter;
    run_remaining_next = run_remaining;
    low_byte_next      = low_byte;
    work_phase         = phase;
    res_valid          = 1'b0;
    res                = '0;
    res.kind           = rlesd_pkg::KIND_PIXEL;
    res.width          = frame_width;
    res.height         = frame_height;
    word               = {data_byte, low_byte};

    // completion left over from a run that ended on a colour word
    if (phase == PH_DONE_PENDING) begin
      res_valid       = 1'b1;
      res.kind        = rlesd_pkg::KIND_DONE;
      res.pixel_index = pixel_counter;
      work_phase      = PH_IDLE;
    end
    // restart at the width field
    if (start_image) begin
      work_phase         = PH_HEADER;
      hdr_count_next     = '0;
      pixel_counter_next = '0;
      run_remaining_next = '0;
    end

    skip_sum   = pixel_counter_next + {25'd0, data_byte[6:0]};
    pix_inc    = pixel_counter_next + 32'd1;
    phase_next = work_phase;

    case (work_phase)
      PH_HEADER: begin
        case (hdr_count_next)
          3'd0: frame_width_next[7:0]   = data_byte;
          3'd1: frame_width_next[15:8]  = data_byte;
          3'd2: frame_height_next[7:0]  = data_byte;
          3'd3: frame_height_next[15:8] = data_byte;
          default: ;
        endcase
        if (hdr_count_next >= rlesd_pkg::HDR_LAST_BYTE) begin
          hdr_count_next     = '0;
          pixel_counter_next = '0;
          run_remaining_next = '0;
          phase_next         = PH_COUNT;
          res_valid          = 1'b1;
          res                = '0;
          res.kind           = rlesd_pkg::KIND_HEADER;
          res.width          = frame_width;
          res.height         = frame_height;
        end else begin
          hdr_count_next = hdr_count_next + 3'd1;
        end
      end
      PH_COUNT: begin
        run_remaining_next = data_byte;
        phase_next         = PH_SKIP;
      end
      PH_SKIP: begin
        pixel_counter_next = skip_sum;
        if (run_remaining_next != 8'd0) begin
          phase_next = PH_LO;
        end else if (skip_sum >= frame_area) begin
          phase_next      = PH_IDLE;
          res_valid       = 1'b1;
          res.kind        = rlesd_pkg::KIND_DONE;
          res.pixel_index = skip_sum;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      PH_LO: begin
        low_byte_next = data_byte;
        phase_next    = PH_HI;
      end
      PH_HI: begin
        res_valid          = 1'b1;
        res.kind           = rlesd_pkg::KIND_PIXEL;
        res.pixel_index    = pixel_counter_next;
        res.alpha          = rlesd_pkg::ALPHA_OPAQUE;
        res.red            = {word[15:11], 3'b000};
        res.green          = {word[10:5], 2'b00};
        res.blue           = {word[4:0], 3'b000};
        res.beyond_frame   = (pixel_counter_next >= frame_area);
        pixel_counter_next = pix_inc;
        run_remaining_next = run_remaining_next - 8'd1;
        if (run_remaining_next != 8'd0) begin
          phase_next = PH_LO;
        end else if (pix_inc >= frame_area) begin
          phase_next = PH_DONE_PENDING;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      default: ;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hdr_count     <= '0;
      frame_width   <= '0;
      frame_height  <= '0;
      pixel_counter <= '0;
      run_remaining <= '0;
      low_byte      <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      hdr_count     <= hdr_count_next;
      frame_width   <= frame_width_next;
      frame_height  <= frame_height_next;
      pixel_counter <= pixel_counter_next;
      run_remaining <= run_remaining_next;
      low_byte      <= low_byte_next;
    end
  end

  // output register and skid entry
  rlesd_out_skid u_out_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept && res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .pop_valid  (out_valid),
    .pop_data   (out_res),
    .pop_ready  (out_ready)
  );

  assign kind         = out_res.kind;
  assign pixel_index  = out_res.pixel_index;
  assign alpha        = out_res.alpha;
  assign red          = out_res.red;
  assign green        = out_res.green;
  assign blue         = out_res.blue;
  assign width        = out_res.width;
  assign height       = out_res.height;
  assign beyond_frame = out_res.beyond_frame;

endmodule
